// ===== rtl/twcm_pkg.sv =====
// twcm_pkg: shared widths, codes and types of the textured wall column mapper
// no dependencies; used by the interfaces, the divider and the top level
package twcm_pkg;

  localparam int COLUMN_W    = 12;
  localparam int WALL_W      = 16;
  localparam int FRAC_W      = 16;
  localparam int FACING_W    = 2;
  localparam int FRAME_ADR_W = 24;
  localparam int TEXEL_ADR_W = 22;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int TEX_LOG2_W  = 4;
  localparam int TEX_LOG2_MAX = 10;
  localparam int TEX_COL_W   = 10;
  localparam int Q16_W       = 32;
  localparam int DIV_W       = 27;
  localparam int OFF_W       = 18;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_ROW   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_SIZE_LOG2 = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
  localparam logic [TEX_LOG2_W-1:0] RST_TEX_SIZE_LOG2 = 4'd6;

  localparam logic [FACING_W-1:0] FACING_EAST = 2'd1;

  typedef struct packed {
    logic busy;
    logic done;
  } twcm_div_stat_t;

endpackage

// ===== rtl/twcm_in_if.sv =====
// twcm_in_if: input channel, one start or row word per handshake
// depends on twcm_pkg
interface twcm_in_if;
  import twcm_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [COLUMN_W-1:0] column;
  logic [WALL_W-1:0]   strip_height;
  logic [FRAC_W-1:0]   hit_x_frac;
  logic [FRAC_W-1:0]   hit_y_frac;
  logic                side_is_horizontal;
  logic [FACING_W-1:0] facing;

  modport source (
    output valid, kind, column, strip_height, hit_x_frac, hit_y_frac,
           side_is_horizontal, facing,
    input  ready
  );
  modport sink (
    input  valid, kind, column, strip_height, hit_x_frac, hit_y_frac,
           side_is_horizontal, facing,
    output ready
  );
endinterface

// ===== rtl/twcm_out_if.sv =====
// twcm_out_if: result channel, one frame/texel address word per handshake
// depends on twcm_pkg
interface twcm_out_if;
  import twcm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FRAME_ADR_W-1:0] frame_address;
  logic [TEXEL_ADR_W-1:0] texel_address;
  logic                   last_row;

  modport source (
    output valid, frame_address, texel_address, last_row,
    input  ready
  );
  modport sink (
    input  valid, frame_address, texel_address, last_row,
    output ready
  );
endinterface

// ===== rtl/twcm_div.sv =====
// twcm_div: iterative restoring divider, one quotient bit per cycle
// depends on twcm_pkg; used by textured_wall_column_mapper_core for the texture step
module twcm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [twcm_pkg::DIV_W-1:0]    dividend,
  input  logic [twcm_pkg::WALL_W-1:0]   divisor,
  output logic [twcm_pkg::DIV_W-1:0]    quotient,
  output twcm_pkg::twcm_div_stat_t      stat
);
  import twcm_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  dq_r;
  logic [WALL_W-1:0] rem_r;
  logic [WALL_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [WALL_W:0]   trial;
  logic [WALL_W:0]   diff;
  logic              qbit;
  logic [WALL_W-1:0] rem_nxt;
  logic [DIV_W-1:0]  dq_nxt;

  assign trial   = {rem_r, dq_r[DIV_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign qbit    = (trial >= {1'b0, dvs_r});
  assign rem_nxt = qbit ? diff[WALL_W-1:0] : trial[WALL_W-1:0];
  assign dq_nxt  = {dq_r[DIV_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = dq_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/textured_wall_column_mapper_core.sv =====
// textured_wall_column_mapper_core: top level of the wall column mapper
// depends on twcm_pkg, twcm_in_if, twcm_out_if and twcm_div
//
// use: a start word (kind 0) sets up one wall strip; each row word (kind 1)
// then yields one result word with the frame address, the texel address and
// a last-row flag, until the strip's rows are used up. row words with no
// strip active yield nothing. a new start word replaces the current strip.
// start: in_ch.ready stays low while the iterative divider runs and then
// during two passes through the one shared multiplier (texture position,
// then frame row base); a zero wall height skips the divider.
// row: one word per cycle, result registered, valid the cycle after accept.
// the result register holds its word while out_ch.ready is low; the block
// takes a new word only when that register is free or being emptied.
// configuration (cfg_we, cfg_index, cfg_data) is to be written by the user
// while idle only; the block does not enforce it.
// reset: synchronous, active low; registers return to 640 x 480, texture
// side 64, and no strip is active.
module textured_wall_column_mapper_core #(
  parameter int MAX_SCREEN_DIM = 4096,
  parameter int TEX_COUNT      = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  twcm_in_if.sink                          in_ch,
  twcm_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [twcm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [twcm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import twcm_pkg::*;

  localparam int DIM_W = $clog2(MAX_SCREEN_DIM + 1);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_DIV      = 2'd1;
  localparam logic [1:0] ST_MUL_POS  = 2'd2;
  localparam logic [1:0] ST_MUL_BASE = 2'd3;

  logic [CFG_DATA_W-1:0] screen_width_r;
  logic [CFG_DATA_W-1:0] screen_height_r;
  logic [TEX_LOG2_W-1:0] tex_size_log2_r;

  logic [1:0]             state_r;
  logic [Q16_W-1:0]       step_r;
  logic [Q16_W-1:0]       pos_r;
  logic [TEX_COL_W-1:0]   tex_col_r;
  logic [FACING_W-1:0]    tex_sel_r;
  logic [DIM_W-1:0]       rows_left_r;
  logic [FRAME_ADR_W-1:0] row_base_r;
  logic [DIM_W-1:0]       top_r;
  logic signed [OFF_W-1:0] off_r;
  logic [COLUMN_W-1:0]    column_r;

  logic                   out_valid_r;
  logic [FRAME_ADR_W-1:0] out_frame_r;
  logic [TEXEL_ADR_W-1:0] out_texel_r;
  logic                   out_last_r;

  // effective configuration
  logic [DIM_W-1:0]      w_eff;
  logic [DIM_W-1:0]      h_eff;
  logic [TEX_LOG2_W-1:0] lg;
  logic [TEX_COL_W-1:0]  tex_mask;

  assign w_eff = (screen_width_r > CFG_DATA_W'(MAX_SCREEN_DIM)) ?
                 DIM_W'(MAX_SCREEN_DIM) : DIM_W'(screen_width_r);
  assign h_eff = (screen_height_r > CFG_DATA_W'(MAX_SCREEN_DIM)) ?
                 DIM_W'(MAX_SCREEN_DIM) : DIM_W'(screen_height_r);
  assign lg = (tex_size_log2_r > TEX_LOG2_W'(TEX_LOG2_MAX)) ?
              TEX_LOG2_W'(TEX_LOG2_MAX) : tex_size_log2_r;
  assign tex_mask = TEX_COL_W'((11'd1 << lg) - 11'd1);

  // handshake
  logic in_fire;
  logic start_fire;
  logic row_fire;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign start_fire  = in_fire && (in_ch.kind == KIND_START);
  assign row_fire    = in_fire && (in_ch.kind == KIND_ROW);

  // column start setup
  logic [DIM_W-1:0]     half_h;
  logic [WALL_W-1:0]    half_up;
  logic [DIM_W-1:0]     top_calc;
  logic signed [OFF_W-1:0] off_calc;
  logic [FRAC_W-1:0]    frac_sel;
  logic [TEX_COL_W-1:0] tex_off;
  logic [TEX_COL_W-1:0] tex_col_calc;
  logic [FACING_W-1:0]  tex_sel_calc;
  logic [DIM_W-1:0]     rows_calc;
  logic                 wall_zero;
  logic [DIV_W-1:0]     div_dividend;

  assign half_h   = h_eff >> 1;
  assign half_up  = WALL_W'(({1'b0, in_ch.strip_height} + 17'd1) >> 1);
  assign top_calc = (WALL_W'(half_h) > half_up) ?
                    DIM_W'(WALL_W'(half_h) - half_up) : '0;
  assign off_calc = $signed(OFF_W'(top_calc)) + $signed(OFF_W'(in_ch.strip_height >> 1))
                  - $signed(OFF_W'(half_h));
  assign frac_sel = in_ch.side_is_horizontal ? in_ch.hit_x_frac : in_ch.hit_y_frac;
  assign tex_off  = TEX_COL_W'(frac_sel >> (5'd16 - 5'(lg)));
  assign tex_col_calc = (in_ch.facing <= FACING_EAST) ? (tex_mask - tex_off) : tex_off;
  assign tex_sel_calc = (32'(in_ch.facing) < 32'(TEX_COUNT)) ?
                        in_ch.facing : FACING_W'(TEX_COUNT - 1);
  assign rows_calc = (32'(in_ch.strip_height) < 32'(h_eff)) ?
                     DIM_W'(in_ch.strip_height) : h_eff;
  assign wall_zero = (in_ch.strip_height == '0);
  assign div_dividend = DIV_W'(1) << (5'(lg) + 5'd16);

  // iterative divider for the texture step
  logic [DIV_W-1:0] div_q;
  twcm_div_stat_t   div_stat;

  twcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_fire && !wall_zero),
    .dividend (div_dividend),
    .divisor  (in_ch.strip_height),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // shared multiplier: position = offset * step, then base = top * width
  logic signed [OFF_W-1:0]   mul_a;
  logic signed [DIV_W:0]     mul_b;
  logic signed [OFF_W+DIV_W:0] mul_p;

  assign mul_a = (state_r == ST_MUL_POS) ? off_r : $signed(OFF_W'(top_r));
  assign mul_b = (state_r == ST_MUL_POS) ? $signed({1'b0, step_r[DIV_W-1:0]})
                                         : $signed((DIV_W+1)'(w_eff));
  assign mul_p = mul_a * mul_b;

  // row address generation
  logic [Q16_W-1:0]       pos_mag;
  logic [FRAC_W-1:0]      pos_int;
  logic [TEX_COL_W-1:0]   row_int;
  logic [TEX_COL_W-1:0]   tex_row;
  logic [TEXEL_ADR_W-1:0] texel_calc;

  assign pos_mag = pos_r[Q16_W-1] ? (~pos_r + 32'd1) : pos_r;
  assign pos_int = pos_mag[Q16_W-1:16];
  assign row_int = pos_r[Q16_W-1] ? TEX_COL_W'(-pos_int) : TEX_COL_W'(pos_int);
  assign tex_row = row_int & tex_mask;
  assign texel_calc = (TEXEL_ADR_W'(tex_sel_r) << {lg, 1'b0})
                    + (TEXEL_ADR_W'(tex_row) << lg)
                    + TEXEL_ADR_W'(tex_col_r);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= RST_SCREEN_WIDTH;
      screen_height_r <= RST_SCREEN_HEIGHT;
      tex_size_log2_r <= RST_TEX_SIZE_LOG2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        CFG_TEX_SIZE_LOG2: tex_size_log2_r <= cfg_data[TEX_LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and column state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      pos_r       <= '0;
      tex_col_r   <= '0;
      tex_sel_r   <= '0;
      rows_left_r <= '0;
      row_base_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start_fire) begin
            tex_col_r   <= tex_col_calc;
            tex_sel_r   <= tex_sel_calc;
            rows_left_r <= rows_calc;
            if (wall_zero) begin
              step_r  <= '0;
              state_r <= ST_MUL_POS;
            end else begin
              state_r <= ST_DIV;
            end
          end else if (row_fire && rows_left_r != '0) begin
            pos_r       <= pos_r + step_r;
            row_base_r  <= row_base_r + FRAME_ADR_W'(w_eff);
            rows_left_r <= rows_left_r - 1'b1;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            step_r  <= Q16_W'(div_q);
            state_r <= ST_MUL_POS;
          end
        end
        ST_MUL_POS: begin
          pos_r   <= mul_p[Q16_W-1:0];
          state_r <= ST_MUL_BASE;
        end
        ST_MUL_BASE: begin
          row_base_r <= mul_p[FRAME_ADR_W-1:0] + FRAME_ADR_W'(column_r);
          state_r    <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start_fire) begin
      top_r    <= top_calc;
      off_r    <= off_calc;
      column_r <= in_ch.column;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (row_fire && rows_left_r != '0) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_fire && rows_left_r != '0) begin
      out_frame_r <= row_base_r;
      out_texel_r <= texel_calc;
      out_last_r  <= (rows_left_r == DIM_W'(1));
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_address = out_frame_r;
  assign out_ch.texel_address = out_texel_r;
  assign out_ch.last_row      = out_last_r;

`ifndef SYNTH
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == ST_IDLE)
    else $error("input ready outside idle");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> state_r == ST_DIV)
    else $error("divider active outside divide state");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_fire |=> state_r != ST_IDLE)
    else $error("start word did not begin setup");

  a_row_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (row_fire && rows_left_r != '0) |=> out_valid_r)
    else $error("active row produced no result word");
`endif

endmodule

// ===== test/textured_wall_column_mapper_core_tb.sv =====
// textured_wall_column_mapper_core_tb: checks the frame and texel address words of the
// wall column mapper against an address predictor, under bursty input and output stalls
// depends on twcm_pkg, twcm_in_if, twcm_out_if and textured_wall_column_mapper_core
module textured_wall_column_mapper_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twcm_pkg::*;

  localparam int SCREEN_MAX    = 4096;
  localparam int TEXTURES      = 4;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 48;
  localparam int REPORT_MAX    = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic                kind;
    logic [COLUMN_W-1:0] column;
    logic [WALL_W-1:0]   wall;
    logic [FRAC_W-1:0]   hit_x_frac;
    logic [FRAC_W-1:0]   hit_y_frac;
    logic                horiz;
    logic [FACING_W-1:0] facing;
  } strip_word_t;

  typedef struct packed {
    logic [FRAME_ADR_W-1:0] frame;
    logic [TEXEL_ADR_W-1:0] texel;
    logic                   last;
  } addr_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  twcm_in_if  in_ch ();
  twcm_out_if out_ch ();

  textured_wall_column_mapper_core #(
    .MAX_SCREEN_DIM(SCREEN_MAX),
    .TEX_COUNT(TEXTURES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of registers and strip state
  logic [CFG_DATA_W-1:0] reg_width  = RST_SCREEN_WIDTH;
  logic [CFG_DATA_W-1:0] reg_height = RST_SCREEN_HEIGHT;
  logic [TEX_LOG2_W-1:0] reg_lg     = RST_TEX_SIZE_LOG2;
  logic [31:0] tex_step = '0;
  logic [31:0] tex_pos  = '0;
  logic [TEX_COL_W-1:0] tex_col = '0;
  logic [1:0]  tex_sel   = '0;
  logic [12:0] rows_left = '0;
  logic [FRAME_ADR_W-1:0] row_base = '0;

  addr_word_t expected_addrs[$];

  int burst_left    = 0;
  int strips_begun  = 0;
  int words_live    = 0;
  int addrs_checked = 0;
  int cfg_writes    = 0;
  int failures      = 0;
  int idle_cycles   = 0;

  function automatic void predict_addresses(input strip_word_t w);
    logic [31:0] lg, size, wd, ht, wall32, half_h, half_up, top, start_off;
    logic [31:0] frac, offset, col32, sel32, base32, trow, mag, texel;
    addr_word_t r;
    lg     = (reg_lg > 4'd10) ? 32'd10 : {28'd0, reg_lg};
    size   = 32'd1 << lg;
    wd     = (reg_width > SCREEN_MAX) ? SCREEN_MAX : {19'd0, reg_width};
    ht     = (reg_height > SCREEN_MAX) ? SCREEN_MAX : {19'd0, reg_height};
    if (w.kind == KIND_START) begin
      wall32    = {16'd0, w.wall};
      half_h    = ht >> 1;
      half_up   = (wall32 + 32'd1) >> 1;
      top       = (half_h > half_up) ? half_h - half_up : 32'd0;
      start_off = top + (wall32 >> 1) - half_h;
      frac      = w.horiz ? {16'd0, w.hit_x_frac} : {16'd0, w.hit_y_frac};
      offset    = (size * frac) >> 16;
      tex_step  = (wall32 != 32'd0) ? (size << 16) / wall32 : 32'd0;
      tex_pos   = start_off * tex_step;
      col32     = (w.facing <= FACING_EAST) ? size - 32'd1 - offset : offset;
      tex_col   = col32[TEX_COL_W-1:0];
      sel32     = ({30'd0, w.facing} < TEXTURES) ? {30'd0, w.facing} : TEXTURES - 1;
      tex_sel   = sel32[1:0];
      rows_left = (wall32 < ht) ? wall32[12:0] : ht[12:0];
      base32    = top * wd + {20'd0, w.column};
      row_base  = base32[FRAME_ADR_W-1:0];
      strips_begun++;
      words_live++;
    end else if (rows_left != 13'd0) begin
      // integer part truncated toward zero
      if (tex_pos[31]) begin
        mag  = (~tex_pos + 32'd1) >> 16;
        trow = 32'd0 - mag;
      end else begin
        trow = tex_pos >> 16;
      end
      trow    = trow & (size - 32'd1);
      sel32   = {30'd0, tex_sel};
      col32   = {22'd0, tex_col};
      texel   = (sel32 << (2 * lg)) + (trow << lg) + col32;
      r.frame = row_base;
      r.texel = texel[TEXEL_ADR_W-1:0];
      r.last  = (rows_left == 13'd1);
      expected_addrs.push_back(r);
      tex_pos   = tex_pos + tex_step;
      row_base  = row_base + wd[FRAME_ADR_W-1:0];
      rows_left = rows_left - 13'd1;
      words_live++;
    end
  endfunction

  function automatic strip_word_t random_word(input logic kind);
    strip_word_t w;
    w.kind       = kind;
    w.column     = COLUMN_W'($urandom_range(0, 4095));
    w.wall       = WALL_W'($urandom_range(0, 65535));
    w.hit_x_frac = FRAC_W'($urandom_range(0, 65535));
    w.hit_y_frac = FRAC_W'($urandom_range(0, 65535));
    w.horiz      = 1'($urandom_range(0, 1));
    w.facing     = FACING_W'($urandom_range(0, 3));
    return w;
  endfunction

  task automatic send_word(input strip_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_ch.valid              <= 1'b1;
    in_ch.kind               <= w.kind;
    in_ch.column             <= w.column;
    in_ch.strip_height       <= w.wall;
    in_ch.hit_x_frac         <= w.hit_x_frac;
    in_ch.hit_y_frac         <= w.hit_y_frac;
    in_ch.side_is_horizontal <= w.horiz;
    in_ch.facing             <= w.facing;
    do @(posedge clk); while (!in_ch.ready);
    predict_addresses(w);
    burst_left--;
  endtask

  task automatic start_strip(input logic [COLUMN_W-1:0] column, input logic [WALL_W-1:0] wall,
                             input logic [FRAC_W-1:0] fx, input logic [FRAC_W-1:0] fy,
                             input logic horiz, input logic [FACING_W-1:0] facing);
    strip_word_t w;
    w.kind       = KIND_START;
    w.column     = column;
    w.wall       = wall;
    w.hit_x_frac = fx;
    w.hit_y_frac = fy;
    w.horiz      = horiz;
    w.facing     = facing;
    send_word(w);
  endtask

  task automatic send_rows(input int n);
    repeat (n) send_word(random_word(KIND_ROW));
  endtask

  task automatic settle(input int cycles);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_addrs.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SCREEN_WIDTH:  reg_width  = data;
      CFG_SCREEN_HEIGHT: reg_height = data;
      CFG_TEX_SIZE_LOG2: reg_lg     = data[TEX_LOG2_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_setting(input int width, input int height, input int lg);
    settle(SETTLE_CYCLES);
    write_reg(CFG_SCREEN_WIDTH, width[CFG_DATA_W-1:0]);
    write_reg(CFG_SCREEN_HEIGHT, height[CFG_DATA_W-1:0]);
    write_reg(CFG_TEX_SIZE_LOG2, lg[CFG_DATA_W-1:0]);
  endtask

  task automatic test_rows_without_strip();
    send_rows(2);
  endtask

  task automatic test_default_strip();
    start_strip(12'd0, 16'd4, 16'h0000, 16'h0000, 1'b0, 2'd0);
    send_rows(5);
  endtask

  task automatic test_strip_replaced();
    start_strip(12'hFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 2'd3);
    send_rows(2);
    start_strip(12'd17, 16'd1, 16'h8000, 16'hFFFF, 1'b0, 2'd2);
    send_rows(1);
  endtask

  task automatic test_zero_height();
    start_strip(12'd5, 16'd0, 16'h1234, 16'hABCD, 1'b1, FACING_EAST);
    send_rows(1);
  endtask

  task automatic test_config_extremes();
    apply_setting(0, 0, 0);
    start_strip(12'd3, 16'd5, 16'hFFFF, 16'hFFFF, 1'b1, 2'd0);
    send_rows(1);
    apply_setting(8191, 8191, 15);
    write_reg(CFG_UNUSED, '1);
    start_strip(12'hFFF, 16'd1, 16'h7FFF, 16'h8001, 1'b0, FACING_EAST);
    send_rows(1);
    apply_setting(1, 1, 1);
    start_strip(12'd100, 16'hFFFF, 16'hC000, 16'h4000, 1'b1, 2'd3);
    send_rows(1);
    apply_setting(4096, 4096, 10);
    start_strip(12'd0, 16'd3, 16'h0001, 16'hFFFE, 1'b0, 2'd2);
    send_rows(3);
  endtask

  task automatic test_backpressure_drain();
    strip_word_t s;
    s      = random_word(KIND_START);
    s.wall = 16'd24;
    send_word(s);
    send_rows(12);
    settle(1);
    send_rows(12);
  endtask

  task automatic test_random_strips(input int width, input int height, input int lg, input int n);
    strip_word_t s;
    int target;
    int rows;
    int pick;
    apply_setting(width, height, lg);
    target = words_live + n;
    while (words_live < target) begin
      if ($urandom_range(0, 9) == 0) send_rows($urandom_range(1, 3));
      s    = random_word(KIND_START);
      pick = $urandom_range(0, 19);
      if (pick == 0) s.wall = 16'd0;
      else if (pick < 14) s.wall = WALL_W'($urandom_range(1, 40));
      else if (pick < 17) s.wall = WALL_W'($urandom_range(41, 300));
      send_word(s);
      rows = int'(rows_left);
      // mostly whole strips, some cut short by the next start
      if ($urandom_range(0, 9) < 8 && rows <= 320)
        send_rows(rows + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0));
      else
        send_rows($urandom_range(0, (rows < 48) ? rows : 48));
    end
    s      = random_word(KIND_START);
    s.wall = 16'd0;
    send_word(s);
  endtask

  // result checker and output stall pattern
  initial begin
    int stall_mode;
    int mode_left;
    int beat;
    addr_word_t exp_w;
    addr_word_t got;
    stall_mode = 0;
    mode_left  = 0;
    beat       = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.frame = out_ch.frame_address;
        got.texel = out_ch.texel_address;
        got.last  = out_ch.last_row;
        if (expected_addrs.size() == 0) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display("unexpected word at %0t: frame %h texel %h last %b",
                     $time, got.frame, got.texel, got.last);
        end else begin
          exp_w = expected_addrs.pop_front();
          addrs_checked++;
          if (got.frame !== exp_w.frame || got.texel !== exp_w.texel ||
              got.last !== exp_w.last) begin
            failures++;
            if (failures <= REPORT_MAX)
              $display("mismatch at %0t: expected frame %h texel %h last %b, ",
                       $time, exp_w.frame, exp_w.texel, exp_w.last,
                       "got frame %h texel %h last %b",
                       got.frame, got.texel, got.last);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 256);
      end
      mode_left--;
      beat++;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ((beat % 8) < 3);
      endcase
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d words still due",
                 idle_cycles, expected_addrs.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_index                <= CFG_SCREEN_WIDTH;
    cfg_data                 <= '0;
    in_ch.valid              <= 1'b0;
    in_ch.kind               <= KIND_ROW;
    in_ch.column             <= '0;
    in_ch.strip_height       <= '0;
    in_ch.hit_x_frac         <= '0;
    in_ch.hit_y_frac         <= '0;
    in_ch.side_is_horizontal <= 1'b0;
    in_ch.facing             <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_rows_without_strip();
    test_default_strip();
    test_strip_replaced();
    test_zero_height();
    test_config_extremes();
    test_backpressure_drain();
    test_random_strips(640, 480, 6, 400);
    test_random_strips(4096, 4096, 10, 400);
    test_random_strips(1, 1, 1, 150);
    test_random_strips(8191, 8191, 15, 400);
    test_random_strips(320, 200, 0, 300);
    test_random_strips(100, 37, 3, 250);

    settle(SETTLE_CYCLES);
    $display("covered %0d strip starts and %0d live words over %0d register writes",
             strips_begun, words_live, cfg_writes);
    $display("compared %0d address words, %0d errors", addrs_checked, failures);
    if (failures == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
